/* rtl/dtmfs_pkg.sv */
// ----------------------------------------------------------------------------
// dtmfs_pkg: shared types and constants of the DTMF coded siren controller
// Mode and phase encodings, result codes, register indexes and command codes.
// ----------------------------------------------------------------------------
package dtmfs_pkg;

   localparam int LEVEL_W    = 11;
   localparam int MODE_W     = 3;
   localparam int EVENT_W    = 3;
   localparam int TICK_W     = 16;
   localparam int STEP_W     = 8;
   localparam int CHAR_W     = 8;
   localparam int SECONDS_W  = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int CODE_SLOTS = 8;

   // growl and alert ramps step once every three ticks
   localparam logic [TICK_W-1:0] RAMP_STEP_TICKS = 16'd3;

   typedef enum logic [4:0] {
      MODE_IDLE   = 5'b00001,
      MODE_GROWL  = 5'b00010,
      MODE_ALERT  = 5'b00100,
      MODE_ATTACK = 5'b01000,
      MODE_DOWN   = 5'b10000
   } mode_type;

   typedef enum logic [2:0] {
      PH_RISE = 3'b001,
      PH_HOLD = 3'b010,
      PH_FALL = 3'b100
   } phase_type;

   // siren_mode result codes
   localparam logic [MODE_W-1:0] SM_IDLE   = 3'd0;
   localparam logic [MODE_W-1:0] SM_GROWL  = 3'd1;
   localparam logic [MODE_W-1:0] SM_ALERT  = 3'd2;
   localparam logic [MODE_W-1:0] SM_ATTACK = 3'd3;
   localparam logic [MODE_W-1:0] SM_DOWN   = 3'd4;

   // code_event result codes
   localparam logic [EVENT_W-1:0] EV_NONE   = 3'd0;
   localparam logic [EVENT_W-1:0] EV_OFF    = 3'd1;
   localparam logic [EVENT_W-1:0] EV_GROWL  = 3'd2;
   localparam logic [EVENT_W-1:0] EV_ALERT  = 3'd3;
   localparam logic [EVENT_W-1:0] EV_ATTACK = 3'd4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROWL     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALERT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ATK_LOW   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ATK_HIGH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ATK_UP    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ATK_DOWN  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD      = 3'd7;

   // command codes, slot 0 in the low byte, unused slots zero
   localparam logic [CODE_SLOTS*CHAR_W-1:0] CODE_OFF    = 64'h0000_0031_3630_3234;
   localparam logic [CODE_SLOTS*CHAR_W-1:0] CODE_GROWL  = 64'h0000_0032_3630_3234;
   localparam logic [CODE_SLOTS*CHAR_W-1:0] CODE_ALERT  = 64'h0000_0033_3630_3234;
   localparam logic [CODE_SLOTS*CHAR_W-1:0] CODE_ATTACK = 64'h0000_0034_3630_3234;

   function automatic logic [MODE_W-1:0] mode_code(input mode_type m);
      logic [MODE_W-1:0] c;
      case (m)
         MODE_GROWL:  c = SM_GROWL;
         MODE_ALERT:  c = SM_ALERT;
         MODE_ATTACK: c = SM_ATTACK;
         MODE_DOWN:   c = SM_DOWN;
         default:     c = SM_IDLE;
      endcase
      return c;
   endfunction

   // a step period of zero acts as one
   function automatic logic [TICK_W-1:0] period_of(input logic [TICK_W-1:0] p);
      return (p == '0) ? TICK_W'(1) : p;
   endfunction

endpackage

/* rtl/dtmf_code_siren_pwm_controller_unit.sv */
// ----------------------------------------------------------------------------
// dtmf_code_siren_pwm_controller_unit: DTMF coded siren PWM controller
// Collects DTMF digits into a command code and steps the siren PWM profile
// on millisecond ticks.
// ----------------------------------------------------------------------------
// Each request is either a 1 ms tick (kind 0) or a received DTMF digit
// (kind 1, with its ASCII character and a seconds timestamp). Every request
// produces exactly one response carrying the PWM level after that item, the
// siren mode, and the command matched by that item (always none for a tick).
// Digits build a CODE_LEN character code; a digit more than TIMEOUT_SECONDS
// after the previous one, or one that follows a full code, starts a new code.
// A full code "42061" winds the siren down, "42062" growls, "42063" alerts and
// "42064" starts the attack sweep; a command takes effect at once. The whole
// state update is one pass of logic from the state registers and the request
// payload into the state and response registers, so a new request is taken
// every cycle while the response register is free or being drained. The
// response is registered and is valid in the cycle after the transfer.
// Configuration writes must only happen while no response is pending.
// ----------------------------------------------------------------------------
module dtmf_code_siren_pwm_controller_unit #(
   parameter int CODE_LEN        = 5,
   parameter int TIMEOUT_SECONDS = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration write port
   input  logic                                 csr_we,
   input  logic [dtmfs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dtmfs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_kind,
   input  logic [dtmfs_pkg::CHAR_W-1:0]         req_digit_char,
   input  logic [dtmfs_pkg::SECONDS_W-1:0]      req_seconds,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [dtmfs_pkg::LEVEL_W-1:0]        rsp_pwm_level,
   output logic [dtmfs_pkg::MODE_W-1:0]         rsp_siren_mode,
   output logic [dtmfs_pkg::EVENT_W-1:0]        rsp_code_event
);
   import dtmfs_pkg::*;

   localparam int CNT_W = $clog2(CODE_LEN + 1);
   localparam logic [CNT_W-1:0] CODE_LEN_C = CNT_W'(CODE_LEN);
   localparam logic [SECONDS_W:0] TIMEOUT_C = (SECONDS_W+1)'(TIMEOUT_SECONDS);

   // configuration registers
   logic [LEVEL_W-1:0] cutoff_ff, growl_lvl_ff, alert_lvl_ff, atk_low_ff, atk_high_ff;
   logic [STEP_W-1:0]  atk_up_ff, atk_down_ff;
   logic [TICK_W-1:0]  hold_ff;

   // block state
   logic [CHAR_W-1:0]    digits_ff [CODE_LEN];
   logic [CHAR_W-1:0]    digits_in [CODE_LEN];
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [SECONDS_W-1:0] last_ff, last_in;
   mode_type             mode_ff, mode_in;
   phase_type            phase_ff, phase_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic [TICK_W-1:0]    tick_ff, tick_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]   rsp_level_ff;
   logic [MODE_W-1:0]    rsp_mode_ff;
   logic [EVENT_W-1:0]   rsp_event_ff, event_in;

   // digit path temporaries
   logic [SECONDS_W-1:0]           last_eff;
   logic                           late;
   logic                           restart;
   logic [CNT_W-1:0]               count_base;
   logic [CODE_SLOTS*CHAR_W-1:0]   code_word;
   logic [TICK_W-1:0]              tick_inc;

   logic req_xfer;

   // Take a new request whenever the response slot is empty or draining.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pwm_level  = rsp_level_ff;
   assign rsp_siren_mode = rsp_mode_ff;
   assign rsp_code_event = rsp_event_ff;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff    <= 11'd550;
         growl_lvl_ff <= 11'd595;
         alert_lvl_ff <= 11'd1024;
         atk_low_ff   <= 11'd750;
         atk_high_ff  <= 11'd1024;
         atk_up_ff    <= 8'd10;
         atk_down_ff  <= 8'd15;
         hold_ff      <= 16'd3000;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CUTOFF:   cutoff_ff    <= csr_wdata[LEVEL_W-1:0];
            CSR_GROWL:    growl_lvl_ff <= csr_wdata[LEVEL_W-1:0];
            CSR_ALERT:    alert_lvl_ff <= csr_wdata[LEVEL_W-1:0];
            CSR_ATK_LOW:  atk_low_ff   <= csr_wdata[LEVEL_W-1:0];
            CSR_ATK_HIGH: atk_high_ff  <= csr_wdata[LEVEL_W-1:0];
            CSR_ATK_UP:   atk_up_ff    <= csr_wdata[STEP_W-1:0];
            CSR_ATK_DOWN: atk_down_ff  <= csr_wdata[STEP_W-1:0];
            CSR_HOLD:     hold_ff      <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // ------------------------------------------------------ next state logic
   assign tick_inc = tick_ff + TICK_W'(1);

   always_comb begin
      digits_in  = digits_ff;
      count_in   = count_ff;
      last_in    = last_ff;
      mode_in    = mode_ff;
      phase_in   = phase_ff;
      level_in   = level_ff;
      tick_in    = tick_ff;
      event_in   = EV_NONE;
      last_eff   = (last_ff == '0) ? req_seconds : last_ff;
      late       = {1'b0, req_seconds} > ({1'b0, last_eff} + TIMEOUT_C);
      restart    = late || (count_ff >= CODE_LEN_C);
      count_base = restart ? '0 : count_ff;
      code_word  = '0;

      if (req_kind) begin
         // Digit: restart the code if late or after a full code, then append.
         last_in = req_seconds;
         for (int i = 0; i < CODE_LEN; i++) begin
            if (restart) begin
               digits_in[i] = '0;
            end
            if (count_base == CNT_W'(i)) begin
               digits_in[i] = req_digit_char;
            end
            code_word[i*CHAR_W +: CHAR_W] = digits_in[i];
         end
         count_in = count_base + CNT_W'(1);

         if (count_in == CODE_LEN_C) begin
            if (code_word == CODE_OFF) begin
               event_in = EV_OFF;
            end else if (code_word == CODE_GROWL) begin
               event_in = EV_GROWL;
            end else if (code_word == CODE_ALERT) begin
               event_in = EV_ALERT;
            end else if (code_word == CODE_ATTACK) begin
               event_in = EV_ATTACK;
            end
         end

         // Apply the matched command at once.
         case (event_in)
            EV_OFF: begin
               mode_in = (mode_ff == MODE_IDLE) ? MODE_IDLE : MODE_DOWN;
            end
            EV_GROWL: begin
               mode_in  = MODE_GROWL;
               level_in = '0;
               tick_in  = '0;
            end
            EV_ALERT: begin
               mode_in  = MODE_ALERT;
               level_in = '0;
               tick_in  = '0;
            end
            EV_ATTACK: begin
               mode_in  = MODE_ATTACK;
               level_in = atk_low_ff;
               phase_in = PH_RISE;
               tick_in  = '0;
            end
            default: ;
         endcase
      end else begin
         // Tick: advance the active profile.
         case (mode_ff)
            MODE_GROWL, MODE_ALERT: begin
               if (level_ff < ((mode_ff == MODE_GROWL) ? growl_lvl_ff : alert_lvl_ff)) begin
                  tick_in = tick_inc;
                  if (tick_inc >= RAMP_STEP_TICKS) begin
                     tick_in  = '0;
                     level_in = level_ff + LEVEL_W'(1);
                  end
               end
            end
            MODE_ATTACK: begin
               case (phase_ff)
                  PH_HOLD: begin
                     tick_in = tick_inc;
                     if (tick_inc >= period_of(hold_ff)) begin
                        tick_in  = '0;
                        phase_in = PH_FALL;
                     end
                  end
                  PH_FALL: begin
                     if (level_ff <= atk_low_ff) begin
                        phase_in = PH_RISE;
                        tick_in  = '0;
                     end else begin
                        tick_in = tick_inc;
                        if (tick_inc >= period_of(TICK_W'(atk_down_ff))) begin
                           tick_in  = '0;
                           level_in = level_ff - LEVEL_W'(1);
                           if (level_in <= atk_low_ff) begin
                              phase_in = PH_RISE;
                           end
                        end
                     end
                  end
                  default: begin
                     phase_in = PH_RISE;
                     if (level_ff >= atk_high_ff) begin
                        phase_in = PH_HOLD;
                        tick_in  = '0;
                     end else begin
                        tick_in = tick_inc;
                        if (tick_inc >= period_of(TICK_W'(atk_up_ff))) begin
                           tick_in  = '0;
                           level_in = level_ff + LEVEL_W'(1);
                           if (level_in >= atk_high_ff) begin
                              phase_in = PH_HOLD;
                           end
                        end
                     end
                  end
               endcase
            end
            MODE_DOWN: begin
               // Wind down to the cutoff, then drop to zero and go idle.
               if (level_ff > cutoff_ff) begin
                  level_in = level_ff - LEVEL_W'(1);
               end else begin
                  level_in = '0;
                  mode_in  = MODE_IDLE;
               end
            end
            default: ;
         endcase
      end
   end

   // Hold the response until it is taken; a transfer refills it.
   assign rsp_valid_in = req_xfer || (rsp_valid_ff && !rsp_ready);

   // ----------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CODE_LEN; i++) begin
            digits_ff[i] <= '0;
         end
         count_ff     <= '0;
         last_ff      <= '0;
         mode_ff      <= MODE_IDLE;
         phase_ff     <= PH_RISE;
         level_ff     <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            digits_ff <= digits_in;
            count_ff  <= count_in;
            last_ff   <= last_in;
            mode_ff   <= mode_in;
            phase_ff  <= phase_in;
            level_ff  <= level_in;
            tick_ff   <= tick_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_level_ff <= level_in;
         rsp_mode_ff  <= mode_code(mode_in);
         rsp_event_ff <= event_in;
      end
   end

   // ---------------------------------------------------------- assertions
   // A tick never reports a matched command.
   a_tick_no_event: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !req_kind) |=> (rsp_code_event == EV_NONE))
      else $error("tick produced a code event");

   // Every transfer yields a response in the next cycle.
   a_xfer_rsp: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_valid)
      else $error("transfer without response");

   // An idle siren always reports a zero PWM level.
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_siren_mode == SM_IDLE) |-> (rsp_pwm_level == '0))
      else $error("idle mode with nonzero level");

   // The digit count never exceeds the code length.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CODE_LEN_C)
      else $error("digit count out of range");

endmodule

/* tb/siren_checker.sv */
// ----------------------------------------------------------------------------
// siren_checker: response predictor and comparator for the DTMF siren unit
// Follows register writes and request transfers, predicts the PWM level, siren
// mode and matched code for each request, and compares every response
// transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module siren_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [dtmfs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dtmfs_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic                             req_kind,
   input  logic [dtmfs_pkg::CHAR_W-1:0]     req_digit_char,
   input  logic [dtmfs_pkg::SECONDS_W-1:0]  req_seconds,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [dtmfs_pkg::LEVEL_W-1:0]    rsp_pwm_level,
   input  logic [dtmfs_pkg::MODE_W-1:0]     rsp_siren_mode,
   input  logic [dtmfs_pkg::EVENT_W-1:0]    rsp_code_event,
   output int                               fail_count,
   output int                               pending,
   output int                               checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import dtmfs_pkg::*;

   localparam int CODE_LEN        = 5;
   localparam int TIMEOUT_SECONDS = 5;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [MODE_W-1:0]  mode;
      logic [EVENT_W-1:0] ev;
   } siren_out_type;

   siren_out_type expected_outs[$];

   // register copies
   logic [LEVEL_W-1:0] cutoff_lv, growl_lv, alert_lv, atk_low, atk_high;
   logic [STEP_W-1:0]  up_per, down_per;
   logic [TICK_W-1:0]  hold_per;

   // siren state
   logic [CODE_SLOTS*CHAR_W-1:0] code_word;
   int                           code_fill;
   logic [SECONDS_W-1:0]         last_secs;
   mode_type                     mode_q;
   phase_type                    phase_q;
   logic [LEVEL_W-1:0]           level_q;
   logic [TICK_W-1:0]            tick_q;

   function automatic logic [TICK_W-1:0] eff_period(input logic [TICK_W-1:0] p);
      if (p == '0) begin
         return TICK_W'(1);
      end
      return p;
   endfunction

   task automatic ramp_step(input logic [LEVEL_W-1:0] target);
      if (level_q < target) begin
         tick_q = tick_q + TICK_W'(1);
         if (tick_q >= RAMP_STEP_TICKS) begin
            tick_q  = '0;
            level_q = level_q + LEVEL_W'(1);
         end
      end
   endtask

   task automatic attack_step();
      case (phase_q)
         PH_HOLD: begin
            tick_q = tick_q + TICK_W'(1);
            if (tick_q >= eff_period(hold_per)) begin
               tick_q  = '0;
               phase_q = PH_FALL;
            end
         end
         PH_FALL: begin
            if (level_q <= atk_low) begin
               phase_q = PH_RISE;
               tick_q  = '0;
            end else begin
               tick_q = tick_q + TICK_W'(1);
               if (tick_q >= eff_period(TICK_W'(down_per))) begin
                  tick_q  = '0;
                  level_q = level_q - LEVEL_W'(1);
                  if (level_q <= atk_low) phase_q = PH_RISE;
               end
            end
         end
         default: begin
            phase_q = PH_RISE;
            if (level_q >= atk_high) begin
               phase_q = PH_HOLD;
               tick_q  = '0;
            end else begin
               tick_q = tick_q + TICK_W'(1);
               if (tick_q >= eff_period(TICK_W'(up_per))) begin
                  tick_q  = '0;
                  level_q = level_q + LEVEL_W'(1);
                  if (level_q >= atk_high) phase_q = PH_HOLD;
               end
            end
         end
      endcase
   endtask

   // advance the siren by one request and report what it should answer
   task automatic step_siren(input logic kind, input logic [CHAR_W-1:0] ch,
                             input logic [SECONDS_W-1:0] secs, output siren_out_type r);
      logic [EVENT_W-1:0] ev;
      ev = EV_NONE;
      if (kind) begin
         if (last_secs == '0) last_secs = secs;
         if ({1'b0, secs} > {1'b0, last_secs} + 33'(TIMEOUT_SECONDS)
             || code_fill >= CODE_LEN) begin
            code_word = '0;
            code_fill = 0;
         end
         last_secs = secs;
         if (code_fill < CODE_LEN) begin
            code_word[CHAR_W*code_fill +: CHAR_W] = ch;
            code_fill++;
            if (code_fill == CODE_LEN) begin
               case (code_word)
                  CODE_OFF:    ev = EV_OFF;
                  CODE_GROWL:  ev = EV_GROWL;
                  CODE_ALERT:  ev = EV_ALERT;
                  CODE_ATTACK: ev = EV_ATTACK;
                  default:     ev = EV_NONE;
               endcase
               case (ev)
                  EV_OFF: begin
                     if (mode_q != MODE_IDLE) mode_q = MODE_DOWN;
                  end
                  EV_GROWL: begin
                     mode_q  = MODE_GROWL;
                     level_q = '0;
                     tick_q  = '0;
                  end
                  EV_ALERT: begin
                     mode_q  = MODE_ALERT;
                     level_q = '0;
                     tick_q  = '0;
                  end
                  EV_ATTACK: begin
                     mode_q  = MODE_ATTACK;
                     level_q = atk_low;
                     phase_q = PH_RISE;
                     tick_q  = '0;
                  end
                  default: ;
               endcase
            end
         end
      end else begin
         case (mode_q)
            MODE_GROWL:  ramp_step(growl_lv);
            MODE_ALERT:  ramp_step(alert_lv);
            MODE_ATTACK: attack_step();
            MODE_DOWN: begin
               if (level_q > cutoff_lv) begin
                  level_q = level_q - LEVEL_W'(1);
               end else begin
                  level_q = '0;
                  mode_q  = MODE_IDLE;
               end
            end
            default: ;
         endcase
      end
      r.level = level_q;
      r.ev    = ev;
      case (mode_q)
         MODE_GROWL:  r.mode = SM_GROWL;
         MODE_ALERT:  r.mode = SM_ALERT;
         MODE_ATTACK: r.mode = SM_ATTACK;
         MODE_DOWN:   r.mode = SM_DOWN;
         default:     r.mode = SM_IDLE;
      endcase
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      siren_out_type want;
      siren_out_type got;
      if (reset) begin
         cutoff_lv = 11'd550;
         growl_lv  = 11'd595;
         alert_lv  = 11'd1024;
         atk_low   = 11'd750;
         atk_high  = 11'd1024;
         up_per    = 8'd10;
         down_per  = 8'd15;
         hold_per  = 16'd3000;
         code_word = '0;
         code_fill = 0;
         last_secs = '0;
         mode_q    = MODE_IDLE;
         phase_q   = PH_RISE;
         level_q   = '0;
         tick_q    = '0;
         expected_outs.delete();
         pending <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CUTOFF:   cutoff_lv = csr_wdata[LEVEL_W-1:0];
               CSR_GROWL:    growl_lv  = csr_wdata[LEVEL_W-1:0];
               CSR_ALERT:    alert_lv  = csr_wdata[LEVEL_W-1:0];
               CSR_ATK_LOW:  atk_low   = csr_wdata[LEVEL_W-1:0];
               CSR_ATK_HIGH: atk_high  = csr_wdata[LEVEL_W-1:0];
               CSR_ATK_UP:   up_per    = csr_wdata[STEP_W-1:0];
               CSR_ATK_DOWN: down_per  = csr_wdata[STEP_W-1:0];
               CSR_HOLD:     hold_per  = csr_wdata[TICK_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            step_siren(req_kind, req_digit_char, req_seconds, want);
            expected_outs.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_pwm_level, rsp_siren_mode, rsp_code_event};
            checked++;
            if (expected_outs.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response, expected nothing, %s %0d mode %0d event %0d",
                        $time, "got level", got.level, got.mode, got.ev);
            end else begin
               want = expected_outs.pop_front();
               check_field("pwm_level", 16'(want.level), 16'(got.level));
               check_field("siren_mode", 16'(want.mode), 16'(got.mode));
               check_field("code_event", 16'(want.ev), 16'(got.ev));
            end
         end
         pending <= expected_outs.size();
      end
   end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench top of the DTMF coded siren PWM controller
// Drives ticks, dialed command codes, broken and noisy digit sequences under
// several register settings with random backpressure on both channels; the
// siren checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dtmfs_pkg::*;

   localparam int CODE_DIGITS = 5;
   localparam int GAP_LIMIT   = 5;
   localparam int CYCLE_LIMIT = 400000;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  csr_we         = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index      = '0;
   logic [CSR_DATA_W-1:0] csr_wdata      = '0;
   logic                  req_valid      = 1'b0;
   logic                  req_kind       = 1'b0;
   logic [CHAR_W-1:0]     req_digit_char = '0;
   logic [SECONDS_W-1:0]  req_seconds    = '0;
   logic                  rsp_ready      = 1'b0;
   logic                  req_ready;
   logic                  rsp_valid;
   logic [LEVEL_W-1:0]    rsp_pwm_level;
   logic [MODE_W-1:0]     rsp_siren_mode;
   logic [EVENT_W-1:0]    rsp_code_event;

   int fail_count;
   int pending;
   int checked;

   // stimulus bookkeeping
   bit          calm = 1'b0;  // when set, neither side inserts random idle cycles
   int          items_sent = 0;
   int          settings_run = 0;
   // track where the digit collector stands so dialed codes line up
   logic [31:0] last_s = '0;
   int          fill = 0;

   dtmf_code_siren_pwm_controller_unit uut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_digit_char (req_digit_char),
      .req_seconds    (req_seconds),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pwm_level  (rsp_pwm_level),
      .rsp_siren_mode (rsp_siren_mode),
      .rsp_code_event (rsp_code_event)
   );

   siren_checker watch (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_digit_char (req_digit_char),
      .req_seconds    (req_seconds),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pwm_level  (rsp_pwm_level),
      .rsp_siren_mode (rsp_siren_mode),
      .rsp_code_event (rsp_code_event),
      .fail_count     (fail_count),
      .pending        (pending),
      .checked        (checked)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Offer one request and hold it until the transfer. An optional idle gap
   // comes first; with no gap, valid simply stays high into the next item.
   task automatic offer_item(input logic kind, input logic [CHAR_W-1:0] ch,
                             input logic [SECONDS_W-1:0] secs);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_digit_char <= ch;
      req_seconds    <= secs;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // ticks carry random filler in the digit fields, which the block must ignore
   task automatic send_tick();
      offer_item(1'b0, CHAR_W'($urandom), $urandom);
   endtask

   task automatic key_digit(input logic [CHAR_W-1:0] ch, input logic [SECONDS_W-1:0] secs);
      // a late digit or one after a full code starts a new code
      if (fill >= CODE_DIGITS
          || (last_s != '0 && {1'b0, secs} > {1'b0, last_s} + 33'(GAP_LIMIT))) begin
         fill = 0;
      end
      fill++;
      last_s = secs;
      offer_item(1'b1, ch, secs);
   endtask

   // advance the timestamp, but never past the top of the seconds range
   function automatic logic [31:0] step_secs(input int step);
      logic [32:0] t;
      t = {1'b0, last_s} + 33'(step);
      return t[32] ? last_s : t[31:0];
   endfunction

   // Dial one of the four command codes. Complete any partial code with a
   // filler that matches nothing, so the command lands on a fresh code. A
   // broken dial stops early; now and then a digit comes late and restarts.
   task automatic dial_code(input bit broken);
      logic [CODE_SLOTS*CHAR_W-1:0] code;
      int n;
      case ($urandom_range(0, 3))
         0:       code = CODE_OFF;
         1:       code = CODE_GROWL;
         2:       code = CODE_ALERT;
         default: code = CODE_ATTACK;
      endcase
      while (fill > 0 && fill < CODE_DIGITS) key_digit("#", step_secs($urandom_range(0, 5)));
      n = broken ? $urandom_range(1, CODE_DIGITS - 1) : CODE_DIGITS;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 11) == 0)
            key_digit(code[CHAR_W*i +: CHAR_W], step_secs($urandom_range(6, 30)));
         else
            key_digit(code[CHAR_W*i +: CHAR_W], step_secs($urandom_range(0, 5)));
      end
   endtask

   // stray digits: any byte, with random, extreme, earlier or late timestamps
   task automatic dial_noise();
      logic [31:0] s;
      repeat ($urandom_range(1, 3)) begin
         case ($urandom_range(0, 4))
            0:       s = $urandom;
            1:       s = '0;
            2:       s = '1;
            3:       s = last_s - 32'($urandom_range(0, 50));
            default: s = step_secs($urandom_range(0, 12));
         endcase
         key_digit(CHAR_W'($urandom_range(0, 255)), s);
      end
   endtask

   // Mostly tick runs and clean commands, the rest broken dials and noise.
   // Long tick runs let the ramps, sweeps and wind-downs play out.
   task automatic run_traffic(input int stop_at);
      int pick;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 15) == 0) calm = !calm;
         pick = $urandom_range(0, 99);
         if (pick < 50)
            repeat ($urandom_range(1, 40)) send_tick();
         else if (pick < 78)
            dial_code(1'b0);
         else if (pick < 86)
            dial_code(1'b1);
         else
            dial_noise();
      end
   endtask

   // drop valid and hold the sender until every response has drained
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
   endtask

   task automatic set_config(input int cutoff, input int growl, input int alert,
                             input int low, input int high, input int up,
                             input int down, input int hold);
      write_reg(CSR_CUTOFF, cutoff);
      write_reg(CSR_GROWL, growl);
      write_reg(CSR_ALERT, alert);
      write_reg(CSR_ATK_LOW, low);
      write_reg(CSR_ATK_HIGH, high);
      write_reg(CSR_ATK_UP, up);
      write_reg(CSR_ATK_DOWN, down);
      write_reg(CSR_HOLD, hold);
      csr_we <= 1'b0;
      settings_run++;
   endtask

   // Response side: a random stall before each response, none while calm.
   // Twice, hold off for a long stretch so requests back up and the block
   // drops its ready while the sender keeps offering.
   initial begin : drain
      int stall;
      int taken;
      taken = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken == 150 || taken == 800)
            stall = 90;
         else
            stall = calm ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         taken++;
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
      $display("** dtmf_code_siren_pwm_controller_unit: FAILED **");
      $finish;
   end

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // tick while idle, then "off" while idle with every digit stamped at second zero
      send_tick();
      for (int i = 0; i < CODE_DIGITS; i++) key_digit(CODE_OFF[CHAR_W*i +: CHAR_W], 32'd0);
      // sixth digit restarts; gap of exactly the limit, then earlier stamps
      key_digit("4", 32'd1);
      key_digit("2", 32'd6);
      key_digit("0", 32'd4);
      key_digit("6", 32'd4);
      key_digit("2", 32'd4);
      // growl ramp takes its first step on the third tick
      repeat (3) send_tick();
      // late first digit, attack dialed at the very top of the seconds range
      for (int i = 0; i < CODE_DIGITS; i++)
         key_digit(CODE_ATTACK[CHAR_W*i +: CHAR_W], 32'hFFFF_FFFB + 32'(i));
      send_tick();
      // off cancels the running attack and starts the wind-down
      for (int i = 0; i < CODE_DIGITS; i++)
         key_digit(CODE_OFF[CHAR_W*i +: CHAR_W], 32'hFFFF_FFFF);
      repeat (2) send_tick();
      settle();

      // random traffic under the reset settings first, then under each setting
      run_traffic(items_sent + 150);
      for (int p = 0; p < 8; p++) begin
         settle();
         case (p)
            0: set_config(3, 5, 8, 4, 9, 1, 2, 2);
            1: set_config(1024, 1024, 1024, 1024, 1024, 255, 255, 65535);
            2: set_config(0, 0, 0, 0, 0, 1, 1, 0);
            // low above high, zero step periods and zero hold
            3: set_config(6, 12, 2, 9, 3, 0, 0, 0);
            4: set_config(20, 40, 60, 10, 30, 2, 3, 6);
            default: set_config($urandom_range(0, 8), $urandom_range(0, 16),
                                $urandom_range(0, 16), $urandom_range(0, 8),
                                $urandom_range(0, 16), $urandom_range(0, 3),
                                $urandom_range(0, 3), $urandom_range(0, 6));
         endcase
         run_traffic(items_sent + 160);
      end

      settle();
      repeat (10) @(posedge clock);
      $display("Covered %0d request transfers and %0d checked responses over %0d settings",
               items_sent, checked, settings_run + 1);
      $display("of the registers: commands, broken dials, noise digits and tick profiles.");
      if (fail_count == 0) begin
         $display("** dtmf_code_siren_pwm_controller_unit: PASSED **");
      end else begin
         $display("** dtmf_code_siren_pwm_controller_unit: FAILED **");
      end
      $finish;
   end

endmodule
